/* src/vnsc_pkg.sv */
// vnsc_pkg: types, constants and codes shared by the nearest-site colorizer
// used by vnsc_cell and voronoi_nearest_site_colorizer_unit
// no dependencies
`default_nettype none

package vnsc_pkg;

  // table size and screen geometry
  localparam int MaxSites = 32;
  localparam int ScreenW  = 640;

  // field widths
  localparam int CoordW = 10;
  localparam int ColorW = 32;
  localparam int SlotW  = 5;
  localparam int SitesW = 6;
  localparam int DistW  = 2 * CoordW + 1;
  localparam int CntW   = $clog2(MaxSites + 1);

  // reset values of the configuration registers
  localparam logic [SitesW-1:0] SitesInUseRst   = SitesW'(20);
  localparam logic              MarkerEnableRst = 1'b1;

  // operation codes
  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  // configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgSitesInUse   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMarkerEnable = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [SlotW-1:0]  site_slot;
    logic [CoordW-1:0] site_x;
    logic [CoordW-1:0] site_y;
    logic [ColorW-1:0] site_color;
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [ColorW-1:0] pixel_color;
    logic [SlotW-1:0]  nearest_slot;
    logic              is_marker;
  } out_item_t;

  // site write command broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [SlotW-1:0]  slot;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ColorW-1:0] color;
  } site_wr_t;

  // query token handed from cell to cell
  typedef struct packed {
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [DistW-1:0]  best_dist;
    logic [SlotW-1:0]  best_slot;
    logic [ColorW-1:0] best_color;
    logic              marker;
  } token_t;

endpackage

`default_nettype wire

/* src/voronoi_nearest_site_colorizer_unit.sv */
// voronoi_nearest_site_colorizer_unit: top level, config registers, cell
// chain and output register
// depends on vnsc_pkg and vnsc_cell
`default_nettype none

// A site write is stored at the accepting edge and gives no result. A pixel
// query walks a chain of 32 cells, one cell (one stored site) per cycle while
// the chain is not held: the first cell loads at the accepting edge and the
// output register loads from the last cell. The chain holds one query at a
// time; the next transaction of either kind is taken once the query has left
// the last cell, even while its result still waits in the output register, so
// a new query is not taken before the last one has left the chain. Writes go
// at one per cycle while no query is in the chain. Configuration writes apply
// at once and should only be made when the block is idle.
module voronoi_nearest_site_colorizer_unit import vnsc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_item_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_item_t               out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [SitesW-1:0]  cfg_wdata_i
);

  logic [SitesW-1:0] sites_in_use_q;
  logic              marker_enable_q;
  logic [CntW-1:0]   count;

  token_t            tok   [MaxSites+1];
  token_t            tok_in;
  logic [MaxSites:0] tok_valid;
  site_wr_t          wr;
  logic              accept, adv, busy;

  logic              out_valid_q;
  out_item_t         out_q, out_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sites_in_use_q  <= SitesInUseRst;
      marker_enable_q <= MarkerEnableRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSitesInUse:   sites_in_use_q  <= cfg_wdata_i;
        CfgMarkerEnable: marker_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // scanned slot count, clamped to 1..MaxSites
  always_comb begin
    if (sites_in_use_q == '0) begin
      count = CntW'(1);
    end else if (int'(sites_in_use_q) > MaxSites) begin
      count = CntW'(MaxSites);
    end else begin
      count = CntW'(sites_in_use_q);
    end
  end

  // input handshake and chain entry
  assign busy       = |tok_valid[MaxSites:1];
  assign in_ready_o = !busy;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    wr.en    = accept && (in_data_i.operation == OpWrite);
    wr.slot  = in_data_i.site_slot;
    wr.x     = in_data_i.site_x;
    wr.y     = in_data_i.site_y;
    wr.color = in_data_i.site_color;

    tok_in    = '0;
    tok_in.px = in_data_i.pixel_x;
    tok_in.py = in_data_i.pixel_y;
  end

  assign tok[0]       = tok_in;
  assign tok_valid[0] = accept && (in_data_i.operation == OpQuery);

  // chain holds while the finished query cannot move to the output
  assign adv = !(tok_valid[MaxSites] && out_valid_q && !out_ready_i);

  // chain of site cells
  for (genvar g = 0; g < MaxSites; g++) begin : g_cell
    vnsc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .idx_i       (SlotW'(g)),
      .count_i     (count),
      .wr_i        (wr),
      .tok_i       (tok[g]),
      .tok_valid_i (tok_valid[g]),
      .tok_o       (tok[g+1]),
      .tok_valid_o (tok_valid[g+1])
    );
  end

  // result formatting
  always_comb begin
    out_d.pixel_color  = (tok[MaxSites].marker && marker_enable_q) ?
                         '0 : tok[MaxSites].best_color;
    out_d.nearest_slot = tok[MaxSites].best_slot;
    out_d.is_marker    = tok[MaxSites].marker;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tok_valid[MaxSites] && adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid[MaxSites] && adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* src/vnsc_cell.sv */
// vnsc_cell: one site slot of the search chain, holds the site and compares
// the passing query token against it
// depends on vnsc_pkg
`default_nettype none

module vnsc_cell import vnsc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic [SlotW-1:0] idx_i,
  input  wire logic [CntW-1:0]  count_i,
  input  wire site_wr_t         wr_i,
  input  wire token_t           tok_i,
  input  wire logic             tok_valid_i,
  output token_t                tok_o,
  output logic                  tok_valid_o
);

  logic [CoordW-1:0] sx_q, sy_q;
  logic [ColorW-1:0] color_q;
  token_t            tok_q, tok_d;
  logic              valid_q;

  logic [CoordW-1:0]   dx, dy;
  logic [2*CoordW-1:0] dx2, dy2;
  logic [DistW-1:0]    sq_dist;
  logic [CoordW:0]     sx_p1, sy_p1;
  logic                active, take, col, row;

  // site storage, written by slot match
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.slot == idx_i)) begin
      sx_q    <= wr_i.x;
      sy_q    <= wr_i.y;
      color_q <= wr_i.color;
    end
  end

  // squared distance to this site
  always_comb begin
    dx      = (sx_q > tok_i.px) ? (sx_q - tok_i.px) : (tok_i.px - sx_q);
    dy      = (sy_q > tok_i.py) ? (sy_q - tok_i.py) : (tok_i.py - sy_q);
    dx2     = (2*CoordW)'(dx) * (2*CoordW)'(dx);
    dy2     = (2*CoordW)'(dy) * (2*CoordW)'(dy);
    sq_dist = {1'b0, dx2} + {1'b0, dy2};
  end

  // marker square, right column clipped at the screen edge
  always_comb begin
    sx_p1 = {1'b0, sx_q} + (CoordW+1)'(1);
    sy_p1 = {1'b0, sy_q} + (CoordW+1)'(1);
    col   = (tok_i.px == sx_q) ||
            (({1'b0, tok_i.px} == sx_p1) && (sx_p1 < (CoordW+1)'(ScreenW)));
    row   = (tok_i.py == sy_q) || ({1'b0, tok_i.py} == sy_p1);
  end

  // update of the running best, lowest slot wins on ties
  always_comb begin
    active = CntW'(idx_i) < count_i;
    take   = active && ((idx_i == '0) || (sq_dist < tok_i.best_dist));
    tok_d  = tok_i;
    if (take) begin
      tok_d.best_dist  = sq_dist;
      tok_d.best_slot  = idx_i;
      tok_d.best_color = color_q;
    end
    tok_d.marker = tok_i.marker | (active & col & row);
  end

  // token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o       = tok_q;
  assign tok_valid_o = valid_q;

endmodule

`default_nettype wire

/* tb/sv/voronoi_nearest_site_colorizer_unit_tb.sv */
// voronoi_nearest_site_colorizer_unit_tb: self-checking testbench for the nearest-site colorizer
// directed table then random site writes and pixel queries, checked against a local predictor
// depends on vnsc_pkg and voronoi_nearest_site_colorizer_unit
module voronoi_nearest_site_colorizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vnsc_pkg::*;

  localparam int ClkPeriod     = 20;
  localparam int ResetCycles   = 10;
  localparam int DrainCycles   = 40;
  localparam int WatchdogLimit = 2000;
  localparam int ReportLimit   = 10;
  localparam int PhaseItems    = 64;
  localparam int PressureOdds  = 60;
  localparam int NumPhases     = 6;

  // per phase: sites scanned (-1 picks one at random), marker drawing, idle odds
  localparam int PhaseSites   [NumPhases] = '{32, 1, 63, 17, -1, 9};
  localparam int PhaseMarker  [NumPhases] = '{1, 0, 0, 1, 1, 0};
  localparam int PhaseSrcIdle [NumPhases] = '{36, 36, 57, 57, 0, 0};
  localparam int PhaseDstIdle [NumPhases] = '{57, 57, 36, 36, 0, 0};

  // coordinates around the screen and field edges
  localparam int EdgeCoords [8] = '{0, 1, 638, 639, 640, 641, 1022, 1023};

  typedef struct {
    bit                 is_cfg;
    logic [CfgIdxW-1:0] reg_idx;
    logic [SitesW-1:0]  reg_val;
    in_item_t           item;
    bit                 known;
    out_item_t          want;
  } stim_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  in_item_t           in_data_i   = '0;
  logic               out_ready_i = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [SitesW-1:0]  cfg_wdata_i = '0;
  logic               in_ready_o;
  logic               out_valid_o;
  out_item_t          out_data_o;

  // predictor copy of the site table and registers
  logic [CoordW-1:0] site_x_tbl   [MaxSites];
  logic [CoordW-1:0] site_y_tbl   [MaxSites];
  logic [ColorW-1:0] site_rgb_tbl [MaxSites];
  logic [SitesW-1:0] sites_scanned_reg = SitesInUseRst;
  logic              marker_draw_reg   = MarkerEnableRst;

  out_item_t expected_pixels [$];
  stim_row_t directed_rows [$];
  int        fail_count   = 0;
  int        quiet_cycles = 0;
  int        src_idle_pct = 36;
  int        dst_idle_pct = 57;

  voronoi_nearest_site_colorizer_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // number of slots a query walks, after clamping the register
  function automatic int scan_limit();
    if (sites_scanned_reg == 0) return 1;
    if (sites_scanned_reg > MaxSites) return MaxSites;
    return int'(sites_scanned_reg);
  endfunction

  // nearest site by squared distance, lowest slot on ties, plus marker hit
  function automatic out_item_t predict_pixel(input in_item_t q);
    out_item_t res;
    int        px, py, sx, sy, dx, dy, d, best_d, best;
    bit        mark;
    px     = int'(q.pixel_x);
    py     = int'(q.pixel_y);
    best   = 0;
    best_d = 0;
    mark   = 1'b0;
    for (int i = 0; i < scan_limit(); i++) begin
      sx = int'(site_x_tbl[i]);
      sy = int'(site_y_tbl[i]);
      dx = (sx > px) ? sx - px : px - sx;
      dy = (sy > py) ? sy - py : py - sy;
      d  = dx * dx + dy * dy;
      if (i == 0 || d < best_d) begin
        best_d = d;
        best   = i;
      end
      // marker column right of the site is clipped at the screen edge
      if ((px == sx || (px == sx + 1 && sx + 1 < ScreenW)) && (py == sy || py == sy + 1)) begin
        mark = 1'b1;
      end
    end
    res.pixel_color  = (mark && marker_draw_reg) ? '0 : site_rgb_tbl[best];
    res.nearest_slot = SlotW'(best);
    res.is_marker    = mark;
    return res;
  endfunction

  // coordinate biased toward edges and a small crowded corner
  function automatic logic [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        return CoordW'(EdgeCoords[$urandom_range(0, 7)]);
      end
      1, 2, 3: begin
        return CoordW'($urandom_range(0, 15));
      end
      default: begin
        return CoordW'($urandom_range(0, 1023));
      end
    endcase
  endfunction

  // coordinate from one step below to two steps above a site, to land on markers
  function automatic logic [CoordW-1:0] near_coord(input logic [CoordW-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 3)) - 1;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return CoordW'(v);
  endfunction

  function automatic in_item_t random_item();
    logic [95:0] raw;
    in_item_t    it;
    int          s;
    raw = {$urandom(), $urandom(), $urandom()};
    it  = raw[$bits(in_item_t)-1:0];
    if ($urandom_range(0, 99) < 35) begin
      it.operation = OpWrite;
      it.site_x    = pick_coord();
      it.site_y    = pick_coord();
    end else begin
      it.operation = OpQuery;
      if ($urandom_range(0, 9) < 4) begin
        s          = $urandom_range(0, scan_limit() - 1);
        it.pixel_x = near_coord(site_x_tbl[s]);
        it.pixel_y = near_coord(site_y_tbl[s]);
      end else begin
        it.pixel_x = pick_coord();
        it.pixel_y = pick_coord();
      end
    end
    return it;
  endfunction

  // table row builders
  function automatic stim_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [SitesW-1:0] val);
    stim_row_t r;
    r         = '{default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t site_row(input int slot, input int x, input int y,
                                         input logic [ColorW-1:0] color);
    stim_row_t r;
    r                 = '{default: '0};
    r.item.operation  = OpWrite;
    r.item.site_slot  = SlotW'(slot);
    r.item.site_x     = CoordW'(x);
    r.item.site_y     = CoordW'(y);
    r.item.site_color = color;
    return r;
  endfunction

  function automatic stim_row_t pixel_row(input int px, input int py);
    stim_row_t r;
    r                = '{default: '0};
    r.item.operation = OpQuery;
    r.item.pixel_x   = CoordW'(px);
    r.item.pixel_y   = CoordW'(py);
    return r;
  endfunction

  function automatic stim_row_t known_pixel(input int px, input int py,
                                            input logic [ColorW-1:0] color,
                                            input int slot, input bit mark);
    stim_row_t r;
    r                   = pixel_row(px, py);
    r.known             = 1'b1;
    r.want.pixel_color  = color;
    r.want.nearest_slot = SlotW'(slot);
    r.want.is_marker    = mark;
    return r;
  endfunction

  // offer one transaction, then account for it at the accepting edge
  task automatic send_item(input in_item_t it, input bit known, input out_item_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.operation == OpWrite) begin
      site_x_tbl[it.site_slot]   = it.site_x;
      site_y_tbl[it.site_slot]   = it.site_y;
      site_rgb_tbl[it.site_slot] = it.site_color;
    end else begin
      expected_pixels.push_back(known ? want : predict_pixel(it));
    end
  endtask

  // stop offering until all results are back and the last query has drained
  task automatic hold_until_idle();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [SitesW-1:0] val);
    hold_until_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgSitesInUse) sites_scanned_reg = val;
    else marker_draw_reg = val[0];
  endtask

  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    if (expected_pixels.size() == 0) begin
      fail_count++;
      if (fail_count <= ReportLimit) begin
        $display("unexpected result: color %h slot %0d marker %0b",
                 got.pixel_color, got.nearest_slot, got.is_marker);
      end
    end else begin
      want = expected_pixels.pop_front();
      if (got.pixel_color !== want.pixel_color || got.nearest_slot !== want.nearest_slot ||
          got.is_marker !== want.is_marker) begin
        fail_count++;
        if (fail_count <= ReportLimit) begin
          $display("mismatch: expected color %h slot %0d marker %0b, got color %h slot %0d marker %0b",
                   want.pixel_color, want.nearest_slot, want.is_marker,
                   got.pixel_color, got.nearest_slot, got.is_marker);
        end
      end
    end
  endtask

  // result side: check each transaction, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_pixel(out_data_o);
    out_ready_i <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    in_item_t  it;
    int        sites_val;

    // directed rows, three sites first so no unwritten slot is scanned
    directed_rows.push_back(cfg_row(CfgSitesInUse, SitesW'(3)));
    directed_rows.push_back(site_row(0, 0, 0, 32'hFFFF_FFFF));
    directed_rows.push_back(site_row(1, 1023, 1023, 32'h80FF_00FF));
    directed_rows.push_back(site_row(2, 10, 0, 32'h0000_0000));
    directed_rows.push_back(known_pixel(0, 0, 32'h0, 0, 1'b1));
    directed_rows.push_back(known_pixel(1023, 1023, 32'h0, 1, 1'b1));
    // equal distance to slots 0 and 2, lower slot wins
    directed_rows.push_back(known_pixel(5, 0, 32'hFFFF_FFFF, 0, 1'b0));
    directed_rows.push_back(known_pixel(1, 1, 32'h0, 0, 1'b1));
    directed_rows.push_back(known_pixel(1022, 1023, 32'h80FF_00FF, 1, 1'b0));
    directed_rows.push_back(pixel_row(600, 300));
    // markers reported but not drawn
    directed_rows.push_back(cfg_row(CfgMarkerEnable, SitesW'(0)));
    directed_rows.push_back(known_pixel(0, 0, 32'hFFFF_FFFF, 0, 1'b1));
    directed_rows.push_back(known_pixel(11, 1, 32'h0, 2, 1'b1));
    directed_rows.push_back(site_row(31, 1023, 1023, 32'hA5A5_A5A5));
    directed_rows.push_back(site_row(2, 639, 500, 32'h5A5A_5A5A));
    directed_rows.push_back(cfg_row(CfgMarkerEnable, SitesW'(1)));
    // marker clipped at the right screen edge
    directed_rows.push_back(known_pixel(640, 500, 32'h5A5A_5A5A, 2, 1'b0));
    directed_rows.push_back(known_pixel(639, 501, 32'h0, 2, 1'b1));
    directed_rows.push_back(site_row(1, 638, 700, 32'h0000_FFFF));
    directed_rows.push_back(known_pixel(639, 701, 32'h0, 1, 1'b1));
    // zero count scans slot 0 alone
    directed_rows.push_back(cfg_row(CfgSitesInUse, SitesW'(0)));
    directed_rows.push_back(known_pixel(639, 500, 32'hFFFF_FFFF, 0, 1'b0));
    directed_rows.push_back(pixel_row(1023, 0));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.is_cfg) write_cfg(row.reg_idx, row.reg_val);
      else send_item(row.item, row.known, row.want);
    end

    // random phases, each with its own register setting and idle pattern
    for (int p = 0; p < NumPhases; p++) begin
      sites_val = (PhaseSites[p] < 0) ? $urandom_range(2, 31) : PhaseSites[p];
      write_cfg(CfgSitesInUse, SitesW'(sites_val));
      write_cfg(CfgMarkerEnable, SitesW'(PhaseMarker[p]));
      src_idle_pct = PhaseSrcIdle[p];
      dst_idle_pct = PhaseDstIdle[p];
      // fill every slot before any wide scan
      if (p == 0) begin
        for (int s = 0; s < MaxSites; s++) begin
          it           = random_item();
          it.operation = OpWrite;
          it.site_slot = SlotW'(s);
          send_item(it, 1'b0, '0);
        end
      end
      repeat (PhaseItems) begin
        if ($urandom_range(0, PressureOdds - 1) == 0) hold_until_idle();
        send_item(random_item(), 1'b0, '0);
      end
    end

    hold_until_idle();
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/vnsc_pkg.sv
src/vnsc_cell.sv
src/voronoi_nearest_site_colorizer_unit.sv
tb/sv/voronoi_nearest_site_colorizer_unit_tb.sv
